[rtl/tpte_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and the arctangent table for the two-point track extrapolator.
// No dependencies; imported by the top level.
package tpte_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int SLOPE_BITS     = 24;
  localparam int SLOPE_FRAC     = 16;
  localparam int ANGLE_BITS     = 17;
  localparam int ANGLE_MAX      = 102944;
  localparam int ANGLE_LIMIT    = 26;   // magnitudes scaled below 2^26 for the angle
  localparam int SQRT_STEPS     = 32;   // root bits of a 64-bit radicand
  localparam int SQRT_RW        = 34;   // remainder width of the root
  localparam int CORDIC_STEPS   = 20;
  localparam int CORDIC_W       = 56;
  localparam int CORDIC_FRAC    = 20;
  localparam int Z_PRESHIFT     = 5;    // |dz| times 32 against the root of 1024*r^2
  localparam int ATAN_W         = 20;
  localparam int ZACC_W         = 23;

  // Register indexes
  localparam logic REG_WINDOW_Z = 1'b0;

  // atan(2^-i) in units of 2^-20 rad
  function automatic logic [ATAN_W-1:0] atan_f(input int unsigned i);
    logic [ATAN_W-1:0] r;
    case (i)
      0:       r = 20'd823550;
      1:       r = 20'd486170;
      2:       r = 20'd256879;
      3:       r = 20'd130396;
      4:       r = 20'd65451;
      5:       r = 20'd32757;
      6:       r = 20'd16383;
      7:       r = 20'd8192;
      8:       r = 20'd4096;
      9:       r = 20'd2048;
      10:      r = 20'd1024;
      11:      r = 20'd512;
      12:      r = 20'd256;
      13:      r = 20'd128;
      14:      r = 20'd64;
      15:      r = 20'd32;
      16:      r = 20'd16;
      17:      r = 20'd8;
      18:      r = 20'd4;
      19:      r = 20'd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/tpte_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider: round-half-up of a*b/d, one quotient bit per stage.
// Standalone; instantiated by two_point_track_extrapolator. The quotient is registered.
module tpte_div #(
  parameter int AW = 25,
  parameter int BW = 25,
  parameter int DW = 25,
  parameter int QB = 25
) (
  input  logic          clk_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  input  logic [DW-1:0] d_i,
  output logic [QB-1:0] quot_o,
  output logic          ovf_o
);

  localparam int BL   = (BW + 1) / 2;
  localparam int BH   = BW - BL;
  localparam int PW   = AW + BW;
  localparam int NW   = PW + 2;
  localparam int EW   = DW + 1;
  localparam int RW   = DW + 2;
  localparam int HW   = NW - QB;
  localparam int CMPW = (HW > EW) ? HW : EW;

  logic [AW+BL-1:0] plo_q;
  logic [AW+BH-1:0] phi_q;
  logic [DW-1:0]    d0_q;

  logic [NW-1:0] prod;
  logic [NW-1:0] num;
  logic [EW-1:0] den0;
  logic          ovf0;

  logic [RW-1:0] rem_q [QB+1];
  logic [QB-1:0] low_q [QB+1];
  logic [QB-1:0] quo_q [QB+1];
  logic [EW-1:0] den_q [QB+1];
  logic          ovf_q [QB+1];

  // Split the product in two halves of b
  always_ff @(posedge clk_i) begin
    plo_q <= a_i * b_i[BL-1:0];
    phi_q <= a_i * b_i[BW-1:BL];
    d0_q  <= d_i;
  end

  // Numerator 2ab+d over 2d gives the rounded quotient
  always_comb begin
    prod = (NW'(phi_q) << BL) + NW'(plo_q);
    num  = {prod[NW-2:0], 1'b0} + NW'(d0_q);
    den0 = {d0_q, 1'b0};
    ovf0 = CMPW'(num[NW-1:QB]) >= CMPW'(den0);
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= RW'(num[NW-1:QB]);
    low_q[0] <= num[QB-1:0];
    quo_q[0] <= '0;
    den_q[0] <= den0;
    ovf_q[0] <= ovf0;
  end

  // One quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [RW-1:0] trial;
    logic          ge;
    assign trial = {rem_q[k][RW-2:0], low_q[k][QB-1]};
    assign ge    = trial >= RW'(den_q[k]);
    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= ge ? trial - RW'(den_q[k]) : trial;
      low_q[k+1] <= low_q[k] << 1;
      quo_q[k+1] <= {quo_q[k][QB-2:0], ge};
      den_q[k+1] <= den_q[k];
      ovf_q[k+1] <= ovf_q[k];
    end
  end

  assign quot_o = quo_q[QB];
  assign ovf_o  = ovf_q[QB];

endmodule

[rtl/two_point_track_extrapolator.sv]
`timescale 1ns / 1ps
// Two-point track extrapolator: window crossing, slopes and polar angle of a straight track.
// Depends on tpte_pkg and tpte_div.
//
// Takes one hit pair per clock; busy never rises. Every accepted beat yields exactly one
// result on done_o. The pipeline depth is set by the 32-stage square root followed by
// the 20-stage CORDIC on the angle path; the four dividers run in parallel and are
// delayed to match. Results are shown for one cycle only and cannot be held off.
// window_z is written through the APB port at byte address 0 and applies to beats accepted
// after the write.
module two_point_track_extrapolator #(
  parameter int COORD_BITS = tpte_pkg::COORD_BITS_DEF,
  localparam int PDATA_W = (COORD_BITS > 32) ? 64 : 32,
  localparam int PADDR_W = (COORD_BITS > 32) ? 4 : 3
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [PADDR_W-1:0]                    paddr,
  input  logic [PDATA_W-1:0]                    pwdata,
  output logic [PDATA_W-1:0]                    prdata,
  output logic                                  pready,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [COORD_BITS-1:0]          up_x_i,
  input  logic signed [COORD_BITS-1:0]          up_y_i,
  input  logic signed [COORD_BITS-1:0]          up_z_i,
  input  logic signed [COORD_BITS-1:0]          down_x_i,
  input  logic signed [COORD_BITS-1:0]          down_y_i,
  input  logic signed [COORD_BITS-1:0]          down_z_i,
  output logic                                  done_o,
  output logic signed [COORD_BITS-1:0]          window_x_o,
  output logic signed [COORD_BITS-1:0]          window_y_o,
  output logic signed [tpte_pkg::SLOPE_BITS-1:0] slope_x_o,
  output logic signed [tpte_pkg::SLOPE_BITS-1:0] slope_y_o,
  output logic [tpte_pkg::ANGLE_BITS-1:0]       polar_angle_o,
  output logic                                  planes_coincide_o
);
  import tpte_pkg::*;

  localparam int DW     = COORD_BITS + 1;
  localparam int QW     = COORD_BITS + 1;
  localparam int SW     = COORD_BITS + 3;
  localparam int SHW    = $clog2(DW);
  localparam int LAT    = 5 + SQRT_STEPS + CORDIC_STEPS + 1;
  localparam int END_S  = LAT - 1;
  localparam int SIDE_N = END_S - 2;
  localparam int PAD_W  = END_S - (4 + QW);
  localparam int PAD_S  = END_S - (4 + SLOPE_BITS);
  localparam int AZ_SH  = Z_PRESHIFT + CORDIC_FRAC;
  localparam logic signed [SW-1:0] WMAX = $signed({4'b0000, {(COORD_BITS-1){1'b1}}});
  localparam logic signed [SW-1:0] WMIN = ~WMAX;
  localparam logic [SLOPE_BITS-1:0] SCAP_POS = {1'b0, {(SLOPE_BITS-1){1'b1}}};
  localparam logic [SLOPE_BITS-1:0] SCAP_NEG = {1'b1, {(SLOPE_BITS-1){1'b0}}};

  typedef struct packed {
    logic                         dz0;
    logic                         wnx;
    logic                         wny;
    logic                         snx;
    logic                         sny;
    logic signed [COORD_BITS-1:0] ux;
    logic signed [COORD_BITS-1:0] uy;
  } side_t;

  function automatic logic [DW-1:0] mag_f(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  function automatic logic [COORD_BITS-1:0] wsat_f(input logic signed [COORD_BITS-1:0] u,
                                                   input logic [QW-1:0] q,
                                                   input logic ovf, input logic neg);
    logic signed [SW-1:0] qe;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] res;
    qe  = $signed({2'b00, q});
    sum = SW'(u) + (neg ? -qe : qe);
    if (ovf)             res = neg ? WMIN : WMAX;
    else if (sum > WMAX) res = WMAX;
    else if (sum < WMIN) res = WMIN;
    else                 res = sum;
    return res[COORD_BITS-1:0];
  endfunction

  function automatic logic [SLOPE_BITS-1:0] ssat_f(input logic [SLOPE_BITS-1:0] q,
                                                   input logic ovf, input logic neg);
    logic [SLOPE_BITS-1:0] cap;
    logic [SLOPE_BITS-1:0] qc;
    cap = neg ? SCAP_NEG : SCAP_POS;
    qc  = (ovf || q > cap) ? cap : q;
    return neg ? -qc : qc;
  endfunction

  // ---------------------------------------------------------------- config port
  logic                  cfg_wr;
  logic [COORD_BITS-1:0] window_z_q;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[PADDR_W-1] == REG_WINDOW_Z) ? PDATA_W'(window_z_q) : '0;

  // Write window_z
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_z_q <= '0;
    end else if (cfg_wr && paddr[PADDR_W-1] == REG_WINDOW_Z) begin
      window_z_q <= pwdata[COORD_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------- valid chain
  logic accept;
  logic vld_q [LAT];

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= accept;
      for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // ---------------------------------------------------------------- stage 1: differences
  logic signed [DW-1:0]         dx_q, dy_q, dz_q, tw_q;
  logic signed [COORD_BITS-1:0] ux1_q, uy1_q;

  always_ff @(posedge clk_i) begin
    dx_q  <= DW'(down_x_i) - DW'(up_x_i);
    dy_q  <= DW'(down_y_i) - DW'(up_y_i);
    dz_q  <= DW'(down_z_i) - DW'(up_z_i);
    tw_q  <= DW'($signed(window_z_q)) - DW'(up_z_i);
    ux1_q <= up_x_i;
    uy1_q <= up_y_i;
  end

  // ---------------------------------------------------------------- stage 2: magnitudes, signs
  logic [DW-1:0] adx2_q, ady2_q, adz2_q, atw2_q;
  side_t         side2_q;

  always_ff @(posedge clk_i) begin
    adx2_q      <= mag_f(dx_q);
    ady2_q      <= mag_f(dy_q);
    adz2_q      <= mag_f(dz_q);
    atw2_q      <= mag_f(tw_q);
    side2_q.dz0 <= dz_q == '0;
    side2_q.wnx <= dx_q[DW-1] ^ tw_q[DW-1] ^ dz_q[DW-1];
    side2_q.wny <= dy_q[DW-1] ^ tw_q[DW-1] ^ dz_q[DW-1];
    side2_q.snx <= dx_q[DW-1] ^ dz_q[DW-1];
    side2_q.sny <= dy_q[DW-1] ^ dz_q[DW-1];
    side2_q.ux  <= ux1_q;
    side2_q.uy  <= uy1_q;
  end

  // Hold the side data until the combine stage
  side_t side_q [SIDE_N];
  always_ff @(posedge clk_i) begin
    side_q[0] <= side2_q;
    for (int i = 1; i < SIDE_N; i++) side_q[i] <= side_q[i-1];
  end

  // ---------------------------------------------------------------- dividers
  logic [QW-1:0]         qwx, qwy;
  logic                  ovwx, ovwy;
  logic [SLOPE_BITS-1:0] qsx, qsy;
  logic                  ovsx, ovsy;

  tpte_div #(.AW(DW), .BW(DW), .DW(DW), .QB(QW)) u_div_wx (
    .clk_i(clk_i), .a_i(adx2_q), .b_i(atw2_q), .d_i(adz2_q), .quot_o(qwx), .ovf_o(ovwx)
  );
  tpte_div #(.AW(DW), .BW(DW), .DW(DW), .QB(QW)) u_div_wy (
    .clk_i(clk_i), .a_i(ady2_q), .b_i(atw2_q), .d_i(adz2_q), .quot_o(qwy), .ovf_o(ovwy)
  );
  tpte_div #(.AW(DW), .BW(SLOPE_FRAC+1), .DW(DW), .QB(SLOPE_BITS)) u_div_sx (
    .clk_i(clk_i), .a_i(adx2_q), .b_i({1'b1, {SLOPE_FRAC{1'b0}}}), .d_i(adz2_q),
    .quot_o(qsx), .ovf_o(ovsx)
  );
  tpte_div #(.AW(DW), .BW(SLOPE_FRAC+1), .DW(DW), .QB(SLOPE_BITS)) u_div_sy (
    .clk_i(clk_i), .a_i(ady2_q), .b_i({1'b1, {SLOPE_FRAC{1'b0}}}), .d_i(adz2_q),
    .quot_o(qsy), .ovf_o(ovsy)
  );

  // Delay the quotients to the combine stage
  logic [2*QW+1:0]         padw_q [PAD_W];
  logic [2*SLOPE_BITS+1:0] pads_q [PAD_S];

  always_ff @(posedge clk_i) begin
    padw_q[0] <= {ovwx, qwx, ovwy, qwy};
    for (int i = 1; i < PAD_W; i++) padw_q[i] <= padw_q[i-1];
    pads_q[0] <= {ovsx, qsx, ovsy, qsy};
    for (int i = 1; i < PAD_S; i++) pads_q[i] <= pads_q[i-1];
  end

  // ---------------------------------------------------------------- stage 3: angle prescale
  logic [DW-1:0]          or_all;
  logic [SHW-1:0]         ash;
  logic [ANGLE_LIMIT-1:0] ax3_q, ay3_q, az3_q;

  // Find the shift that brings all magnitudes below the angle limit
  always_comb begin
    or_all = adx2_q | ady2_q | adz2_q;
    ash    = '0;
    for (int k = ANGLE_LIMIT; k < DW; k++) begin
      if (or_all[k]) ash = SHW'(k - ANGLE_LIMIT + 1);
    end
  end

  always_ff @(posedge clk_i) begin
    ax3_q <= ANGLE_LIMIT'(adx2_q >> ash);
    ay3_q <= ANGLE_LIMIT'(ady2_q >> ash);
    az3_q <= ANGLE_LIMIT'(adz2_q >> ash);
  end

  // ---------------------------------------------------------------- stages 4-5: radicand
  logic [2*ANGLE_LIMIT-1:0] sqx4_q, sqy4_q;
  logic [ANGLE_LIMIT-1:0]   az4_q;

  always_ff @(posedge clk_i) begin
    sqx4_q <= ax3_q * ax3_q;
    sqy4_q <= ay3_q * ay3_q;
    az4_q  <= az3_q;
  end

  logic [SQRT_STEPS-1:0]    sroot_q [SQRT_STEPS+1];
  logic [SQRT_RW-1:0]       srem_q  [SQRT_STEPS+1];
  logic [2*SQRT_STEPS-1:0]  sv_q    [SQRT_STEPS+1];
  logic [ANGLE_LIMIT-1:0]   saz_q   [SQRT_STEPS+1];

  always_ff @(posedge clk_i) begin
    sroot_q[0] <= '0;
    srem_q[0]  <= '0;
    sv_q[0]    <= (64'(sqx4_q) + 64'(sqy4_q)) << 10;
    saz_q[0]   <= az4_q;
  end

  // ---------------------------------------------------------------- square root, one bit a stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [SQRT_RW+1:0] t;
    logic [SQRT_RW+1:0] trial;
    logic               ge;
    assign t     = {srem_q[k], sv_q[k][2*SQRT_STEPS-1 -: 2]};
    assign trial = {2'b00, sroot_q[k], 2'b01};
    assign ge    = t >= trial;
    always_ff @(posedge clk_i) begin
      srem_q[k+1]  <= ge ? SQRT_RW'(t - trial) : SQRT_RW'(t);
      sroot_q[k+1] <= {sroot_q[k][SQRT_STEPS-2:0], ge};
      sv_q[k+1]    <= sv_q[k] << 2;
      saz_q[k+1]   <= saz_q[k];
    end
  end

  // ---------------------------------------------------------------- CORDIC vectoring
  logic signed [CORDIC_W-1:0] cx_q [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] cy_q [CORDIC_STEPS];
  logic signed [ZACC_W-1:0]   cz_q [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CORDIC_W-1:0] xc, yc;
    logic signed [ZACC_W-1:0]   zc;
    logic signed [ZACC_W-1:0]   at;
    if (i == 0) begin : g_first
      assign xc = $signed(CORDIC_W'({saz_q[SQRT_STEPS], {AZ_SH{1'b0}}}));
      assign yc = $signed(CORDIC_W'({sroot_q[SQRT_STEPS], {CORDIC_FRAC{1'b0}}}));
      assign zc = '0;
    end else begin : g_next
      assign xc = cx_q[i-1];
      assign yc = cy_q[i-1];
      assign zc = cz_q[i-1];
    end
    assign at = $signed(ZACC_W'(atan_f(i)));
    // Rotate toward the x axis and accumulate the angle
    always_ff @(posedge clk_i) begin
      if (yc >= 0) begin
        cx_q[i] <= xc + (yc >>> i);
        cy_q[i] <= yc - (xc >>> i);
        cz_q[i] <= zc + at;
      end else begin
        cx_q[i] <= xc - (yc >>> i);
        cy_q[i] <= yc + (xc >>> i);
        cz_q[i] <= zc - at;
      end
    end
  end

  // ---------------------------------------------------------------- combine and drive results
  side_t                    sd;
  logic signed [ZACC_W-1:0] zf;
  logic signed [ZACC_W-1:0] zr;
  logic [ANGLE_BITS-1:0]    ang;
  logic [QW-1:0]            fqwx, fqwy;
  logic                     fowx, fowy;
  logic [SLOPE_BITS-1:0]    fqsx, fqsy;
  logic                     fosx, fosy;

  always_comb begin
    sd   = side_q[SIDE_N-1];
    {fowx, fqwx, fowy, fqwy} = padw_q[PAD_W-1];
    {fosx, fqsx, fosy, fqsy} = pads_q[PAD_S-1];
    zf   = cz_q[CORDIC_STEPS-1];
    zr   = (zf + ZACC_W'(8)) >>> 4;
    if (zf < -8)                 ang = '0;
    else if (zr > ANGLE_MAX)     ang = ANGLE_BITS'(ANGLE_MAX);
    else                         ang = ANGLE_BITS'(zr);
  end

  always_ff @(posedge clk_i) begin
    if (sd.dz0) begin
      window_x_o        <= '0;
      window_y_o        <= '0;
      slope_x_o         <= '0;
      slope_y_o         <= '0;
      polar_angle_o     <= '0;
      planes_coincide_o <= 1'b1;
    end else begin
      window_x_o        <= wsat_f(sd.ux, fqwx, fowx, sd.wnx);
      window_y_o        <= wsat_f(sd.uy, fqwy, fowy, sd.wny);
      slope_x_o         <= ssat_f(fqsx, fosx, sd.snx);
      slope_y_o         <= ssat_f(fqsy, fosy, sd.sny);
      polar_angle_o     <= ang;
      planes_coincide_o <= 1'b0;
    end
  end

  assign done_o = vld_q[LAT-1];

  // ---------------------------------------------------------------- assertions
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(LAT) done_o)
    else $error("accepted beat did not produce a result at the fixed latency");

  a_coincide_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && planes_coincide_o) |-> (window_x_o == '0 && window_y_o == '0 &&
      slope_x_o == '0 && slope_y_o == '0 && polar_angle_o == '0))
    else $error("coincident planes with nonzero result fields");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> polar_angle_o <= ANGLE_BITS'(ANGLE_MAX))
    else $error("polar angle beyond its range");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && paddr[PADDR_W-1] == REG_WINDOW_Z) |=>
      window_z_q == $past(pwdata[COORD_BITS-1:0]))
    else $error("window_z write lost");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for two_point_track_extrapolator: random and corner hit pairs,
// an exact fixed-point predictor and an in-order result scoreboard. Depends on tpte_pkg.
module tb_top;
  import tpte_pkg::*;

  localparam int CB = 24;
  localparam int LATENCY = 58;
  localparam int PAW = 3;
  localparam int PDW = 32;

  typedef struct {
    logic signed [CB-1:0] wx;
    logic signed [CB-1:0] wy;
    logic signed [SLOPE_BITS-1:0] sx;
    logic signed [SLOPE_BITS-1:0] sy;
    logic [ANGLE_BITS-1:0] ang;
    logic coinc;
  } track_t;

  // Exact track predictor: rounding division, saturation and the CORDIC angle
  class track_scoreboard;
    track_t pending[$];
    logic signed [CB-1:0] win_z;
    int errors;

    function new();
      win_z = '0;
      errors = 0;
    endfunction

    // round half away from zero of a*b/d, capped in magnitude
    function longint div_round(longint a, longint b, longint d, longint cap_p, longint cap_n);
      bit neg;
      logic [127:0] num, q;
      longint m;
      neg = (a < 0) ^ (b < 0) ^ (d < 0);
      num = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
      num = num * 2 + 128'(d < 0 ? -d : d);
      q = num / (128'(d < 0 ? -d : d) * 2);
      m = neg ? cap_n : cap_p;
      if (q > 128'(m)) q = 128'(m);
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function longint clamp(longint v, int w);
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    function longint angle(longint dx, longint dy, longint dz);
      longint unsigned ax, ay, az, v, res, bt;
      longint x, y, z, xs, ys;
      longint tab[CORDIC_STEPS];
      tab = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
              1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      az = dz < 0 ? -dz : dz;
      while (ax >= (64'd1 << 26) || ay >= (64'd1 << 26) || az >= (64'd1 << 26)) begin
        ax >>= 1; ay >>= 1; az >>= 1;
      end
      v = (ax * ax + ay * ay) << 10;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt >>= 2;
      while (bt != 0) begin
        if (v >= res + bt) begin
          v -= res + bt;
          res = (res >> 1) + bt;
        end else begin
          res >>= 1;
        end
        bt >>= 2;
      end
      x = longint'((az << 5) << 20);
      y = longint'(res << 20);
      z = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += tab[i];
        end else begin
          x -= ys; y += xs; z -= tab[i];
        end
      end
      if (z < -8) return 0;
      z = (z + 8) >>> 4;
      return z > ANGLE_MAX ? ANGLE_MAX : z;
    endfunction

    // note an accepted hit pair and queue its expected track
    function void note_hits(longint ux, longint uy, longint uz, longint vx, longint vy,
                            longint vz);
      track_t t;
      longint dx, dy, dz, tw, big, sp;
      dx = vx - ux; dy = vy - uy; dz = vz - uz;
      tw = longint'(win_z) - uz;
      big = longint'(1) <<< 62;
      sp = (longint'(1) <<< (SLOPE_BITS - 1)) - 1;
      t = '{default: '0};
      if (dz == 0) begin
        t.coinc = 1'b1;
      end else begin
        t.wx = CB'(clamp(ux + div_round(dx, tw, dz, big, big), CB));
        t.wy = CB'(clamp(uy + div_round(dy, tw, dz, big, big), CB));
        t.sx = SLOPE_BITS'(div_round(dx, 65536, dz, sp, sp + 1));
        t.sy = SLOPE_BITS'(div_round(dy, 65536, dz, sp, sp + 1));
        t.ang = ANGLE_BITS'(angle(dx, dy, dz));
      end
      pending.push_back(t);
    endfunction

    function void check_track(track_t got);
      track_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.wx !== e.wx) begin $error("window_x exp %0d got %0d", e.wx, got.wx); errors++; end
      if (got.wy !== e.wy) begin $error("window_y exp %0d got %0d", e.wy, got.wy); errors++; end
      if (got.sx !== e.sx) begin $error("slope_x exp %0d got %0d", e.sx, got.sx); errors++; end
      if (got.sy !== e.sy) begin $error("slope_y exp %0d got %0d", e.sy, got.sy); errors++; end
      if (got.ang !== e.ang) begin
        $error("polar_angle exp %0d got %0d", e.ang, got.ang); errors++;
      end
      if (got.coinc !== e.coinc) begin
        $error("planes_coincide exp %0d got %0d", e.coinc, got.coinc); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PAW-1:0] paddr = '0;
  logic [PDW-1:0] pwdata = '0;
  logic [PDW-1:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic signed [CB-1:0] up_x_i = '0, up_y_i = '0, up_z_i = '0;
  logic signed [CB-1:0] down_x_i = '0, down_y_i = '0, down_z_i = '0;
  logic done_o;
  logic signed [CB-1:0] window_x_o, window_y_o;
  logic signed [SLOPE_BITS-1:0] slope_x_o, slope_y_o;
  logic [ANGLE_BITS-1:0] polar_angle_o;
  logic planes_coincide_o;

  track_scoreboard sb;
  int idle_pct;

  two_point_track_extrapolator dut (.*);

  initial forever #1 clk_i = ~clk_i;

  // check every result beat
  always @(posedge clk_i) begin
    track_t got;
    if (rst_ni && done_o === 1'b1) begin
      got = '{window_x_o, window_y_o, slope_x_o, slope_y_o, polar_angle_o, planes_coincide_o};
      sb.check_track(got);
    end
  end

  task automatic write_window_z(logic signed [CB-1:0] z);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PAW'(REG_WINDOW_Z) << 2;
    pwdata <= PDW'(z);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.win_z = z;
  endtask

  // drive one beat, holding start until accepted
  task automatic send_hits(logic signed [CB-1:0] ux, uy, uz, vx, vy, vz);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    up_x_i <= ux; up_y_i <= uy; up_z_i <= uz;
    down_x_i <= vx; down_y_i <= vy; down_z_i <= vz;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_hits(ux, uy, uz, vx, vy, vz);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic logic signed [CB-1:0] rnd_coord();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
      1: return CB'($urandom_range(2000)) - 24'sd1000;
      default: return CB'($urandom);
    endcase
  endfunction

  task automatic random_hits();
    logic signed [CB-1:0] uz, vz;
    uz = rnd_coord();
    case ($urandom_range(9))
      0: vz = uz;
      1: vz = uz + CB'($urandom_range(8)) - 24'sd4;
      default: vz = rnd_coord();
    endcase
    send_hits(rnd_coord(), rnd_coord(), uz, rnd_coord(), rnd_coord(), vz);
  endtask

  initial begin
    localparam logic signed [CB-1:0] MX = 24'sh7fffff, MN = 24'sh800000;
    sb = new();
    idle_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed corners at the reset window
    send_hits(0, 0, 0, 0, 0, 0);
    send_hits(10, -20, 100, 10, -20, 100);
    send_hits(0, 0, 0, 256, 0, 256);
    send_hits(0, 0, 0, 0, 256, -256);
    send_hits(MN, MN, MN, MX, MX, MX);
    send_hits(MX, MX, MX, MN, MN, MN);
    send_hits(MN, MX, 0, MX, MN, 1);
    send_hits(0, 0, 0, MX, MN, -1);
    send_hits(1, 1, 0, 2, 2, 2);
    send_hits(-1, -1, 0, -2, -2, 2);
    send_hits(0, 0, MX, 5, -5, MN);
    send_hits(0, 0, 0, 0, 0, 3);
    drain();
    write_window_z(MX);
    send_hits(0, 0, MN, 1, -1, MN + 1);
    send_hits(100, 200, -300, 150, 250, 300);
    send_hits(MX, MN, 0, MX, MN, 7);
    drain();
    write_window_z(MN);
    send_hits(0, 0, MX, 3, -3, MX - 1);
    send_hits(MN, MX, 0, MN, MX, 0);

    // random phases with different windows and sender idling
    for (int ph = 0; ph < 3; ph++) begin
      drain();
      write_window_z(ph == 0 ? 24'sd0 : rnd_coord());
      idle_pct = (ph == 0) ? 32 : (ph == 1) ? 45 : 0;
      for (int n = 0; n < 165; n++) begin
        random_hits();
        if (n == 80) drain();
      end
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
